@@ design/utf8d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants of the utf-8 validating decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;
    localparam logic [CP_W-1:0] MIN_TWO    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR   = 21'h010000;
    localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
    localparam logic [4:0]      SURR_TOP   = 5'b11011;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } q_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            was_error;
        logic            run_last;
        logic            output_end;
    } out_item_t;

    typedef struct packed {
        logic            has;
        logic [2:0]      adv;
        logic [CP_W-1:0] cp;
        logic            err;
    } dec_t;

    typedef enum logic {
        ST_LOAD,
        ST_SCAN
    } state_t;

endpackage

@@ design/utf8d_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_front
// accepts input bytes into a two-entry queue ahead of the scanner
// ----------------------------------------------------------------------------
module utf8d_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // data_byte
    input  logic               s_axis_tlast,   // stream_end
    output logic               q_valid,
    output utf8d_pkg::q_item_t q_item,
    input  logic               q_pop
);
    import utf8d_pkg::*;

    q_item_t    slot0_reg, slot0_next;
    q_item_t    slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    q_item_t    in_item;
    logic       push;
    logic       pop;

    assign in_item.data_byte  = s_axis_tdata;
    assign in_item.stream_end = s_axis_tlast;

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign pop           = q_pop && q_valid;
    assign q_item        = slot0_reg;

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push && pop) begin
            if (count_reg == 2'd1) begin
                slot0_next = in_item;
            end else begin
                slot0_next = slot1_reg;
                slot1_next = in_item;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                slot0_next = in_item;
            end else begin
                slot1_next = in_item;
            end
            count_next = count_reg + 2'd1;
        end else if (pop) begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

@@ design/utf8d_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_back
// holds partial sequences, scans one result per unstalled cycle, output register
// ----------------------------------------------------------------------------
module utf8d_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [utf8d_pkg::CP_W-1:0] cfg_wdata,
    input  logic                       q_valid,
    input  utf8d_pkg::q_item_t         q_item,
    output logic                       q_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output utf8d_pkg::out_item_t       m_item
);
    import utf8d_pkg::*;

    function automatic dec_t decode(input logic [31:0] b, input logic [2:0] n,
                                    input logic fin, input logic [CP_W-1:0] repl);
        dec_t            r;
        logic [7:0]      lead;
        logic [7:0]      c1;
        logic [7:0]      c2;
        logic [7:0]      c3;
        logic [2:0]      need;
        logic [CP_W-1:0] val;
        logic            ok;
        lead  = b[7:0];
        c1    = b[15:8];
        c2    = b[23:16];
        c3    = b[31:24];
        r.has = 1'b0;
        r.adv = 3'd1;
        r.cp  = '0;
        r.err = 1'b0;
        need  = 3'd0;
        val   = '0;
        ok    = 1'b0;
        if (lead[7:5] == 3'b110) begin
            need = 3'd2;
        end else if (lead[7:4] == 4'b1110) begin
            need = 3'd3;
        end else if (lead[7:3] == 5'b11110) begin
            need = 3'd4;
        end
        if (n == 3'd0) begin
            r.has = 1'b0;
        end else if (!lead[7]) begin
            r.has = 1'b1;
            r.cp  = {13'd0, lead};
        end else if (need == 3'd0) begin
            r.has = 1'b1;
            r.err = 1'b1;
            r.cp  = repl;
        end else if (n < need) begin
            if (fin) begin
                r.has = 1'b1;
                r.err = 1'b1;
                r.cp  = repl;
                r.adv = n;
            end
        end else begin
            unique case (need)
                3'd2: begin
                    val = {10'd0, lead[4:0], c1[5:0]};
                    ok  = (c1[7:6] == 2'b10) && (val >= MIN_TWO);
                end
                3'd3: begin
                    val = {5'd0, lead[3:0], c1[5:0], c2[5:0]};
                    ok  = (c1[7:6] == 2'b10) && (c2[7:6] == 2'b10)
                          && (val >= MIN_THREE) && (val[15:11] != SURR_TOP);
                end
                default: begin
                    val = {lead[2:0], c1[5:0], c2[5:0], c3[5:0]};
                    ok  = (c1[7:6] == 2'b10) && (c2[7:6] == 2'b10)
                          && (c3[7:6] == 2'b10)
                          && (val >= MIN_FOUR) && (val <= MAX_SCALAR);
                end
            endcase
            r.has = 1'b1;
            if (ok) begin
                r.cp  = val;
                r.adv = need;
            end else begin
                r.err = 1'b1;
                r.cp  = repl;
            end
        end
        return r;
    endfunction

    state_t          state_reg, state_next;
    logic [31:0]     buf_reg, buf_next;
    logic [2:0]      n_reg, n_next;
    logic            fin_reg, fin_next;
    logic [CP_W-1:0] repl_reg;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_item_reg, m_item_next;
    dec_t            r0;
    dec_t            r1;
    logic [31:0]     buf_shift;
    logic [2:0]      n_after;
    logic [31:0]     keep_mask;
    logic            out_free;

    assign out_free  = !m_valid_reg || m_ready;
    assign keep_mask = ~(32'hFFFF_FFFF << {n_reg, 3'b000});
    assign r0        = decode(buf_reg, n_reg, fin_reg, repl_reg);
    assign buf_shift = buf_reg >> {r0.adv, 3'b000};
    assign n_after   = n_reg - r0.adv;
    assign r1        = decode(buf_shift, n_after, fin_reg, repl_reg);

    assign q_pop   = (state_reg == ST_LOAD) && q_valid;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        state_next   = state_reg;
        buf_next     = buf_reg;
        n_next       = n_reg;
        fin_next     = fin_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (q_valid) begin
                    buf_next   = (buf_reg & keep_mask)
                                 | ({24'd0, q_item.data_byte} << {n_reg, 3'b000});
                    n_next     = n_reg + 3'd1;
                    fin_next   = q_item.stream_end;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!r0.has) begin
                    state_next = ST_LOAD;
                end else if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_item_next.code_point = r0.cp;
                    m_item_next.was_error  = r0.err;
                    m_item_next.run_last   = !r1.has;
                    m_item_next.output_end = fin_reg && !r1.has;
                    buf_next               = buf_shift;
                    n_next                 = n_after;
                    if (!r1.has) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            n_reg       <= 3'd0;
            m_valid_reg <= 1'b0;
            repl_reg    <= REPL_RESET;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                repl_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg    <= buf_next;
        fin_reg    <= fin_next;
        m_item_reg <= m_item_next;
    end

endmodule

@@ design/utf8_validating_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validating_decoder
// utf-8 byte stream to code points, malformed input replaced by a set code
// ----------------------------------------------------------------------------
// path: queue register, then held bytes, then output register
// flow: each byte is loaded, then scanned once per result (once when it gives
//   none) by the single-result scanner; scans wait while the output is full
// reset: empties the queue and held bytes, drops any pending result,
//   replacement code returns to 0xfffd
module utf8_validating_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // stream_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_axis_tuser,   // [0] was_error, [1] run_last
    output logic        m_axis_tlast    // output_end
);
    import utf8d_pkg::*;

    logic      q_valid;
    q_item_t   q_item;
    logic      q_pop;
    out_item_t m_item;

    utf8d_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    utf8d_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_item    (m_item)
    );

    assign m_axis_tdata = {3'b000, m_item.code_point};
    assign m_axis_tuser = {m_item.run_last, m_item.was_error};
    assign m_axis_tlast = m_item.output_end;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the utf-8 validating decoder: bytes go in as
// stream transactions in random bursts, every accepted byte is decoded by
// a behavioral model in the bench, and each result transaction is checked
// field by field against the oldest expected code point. phases run under
// different replacement codes, with long output stalls and full drains
// ----------------------------------------------------------------------------
module tb_top;

    import utf8d_pkg::*;

    localparam int unsigned SURR_FIRST = 32'h0000D800;
    localparam int unsigned SURR_LAST  = 32'h0000DFFF;
    localparam int          TAIL_CYCLES = 10;
    localparam int          HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [20:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0; // stream_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // [20:0] code_point, [23:21] zero
    logic [1:0]  m_axis_tuser;        // [0] was_error, [1] run_last
    logic        m_axis_tlast;        // output_end

    utf8_validating_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 0;
    end

    q_item_t     bytes_to_send[$];
    out_item_t   code_points_due[$];
    logic [7:0]  held_buf[4];
    int          held_n = 0;
    logic [20:0] repl_code = REPL_RESET;
    int          errors = 0;
    int          queued_n = 0;
    int          accepted_n = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          hold_at = -1;
    int          hold_fired = -1;
    int          hold_left = 0;
    int          rx_mode = 0;
    int          rx_cycle = 0;

    function automatic out_item_t make_result(logic [20:0] cp, logic err);
        out_item_t r;
        r.code_point = cp;
        r.was_error  = err;
        r.run_last   = 1'b0;
        r.output_end = 1'b0;
        return r;
    endfunction

    // decodes one accepted byte against the held bytes, queues its results
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [7:0]  win[4];
        out_item_t   res[4];
        int          n;
        int          pos;
        int          k;
        int          need;
        int          off;
        int unsigned cp;
        int unsigned minv;
        bit          ok;
        n = held_n;
        pos = 0;
        k = 0;
        for (int i = 0; i < n; i++) win[i] = held_buf[i];
        win[n] = b;
        n++;
        while (pos < n) begin
            need = 0;
            if (win[pos] < 8'h80) begin
                res[k] = make_result({13'd0, win[pos]}, 1'b0);
                k++;
                pos++;
            end else begin
                if ((win[pos] & 8'hE0) == 8'hC0) begin
                    need = 2; cp = win[pos] & 8'h1F; minv = MIN_TWO;
                end else if ((win[pos] & 8'hF0) == 8'hE0) begin
                    need = 3; cp = win[pos] & 8'h0F; minv = MIN_THREE;
                end else if ((win[pos] & 8'hF8) == 8'hF0) begin
                    need = 4; cp = win[pos] & 8'h07; minv = MIN_FOUR;
                end
                if (need == 0) begin
                    res[k] = make_result(repl_code, 1'b1);
                    k++;
                    pos++;
                end else if (n - pos < need) begin
                    break;
                end else begin
                    ok = 1'b1;
                    for (off = 1; off < need; off++) begin
                        if ((win[pos+off] & 8'hC0) != 8'h80) ok = 1'b0;
                        else if (ok) cp = (cp << 6) | (win[pos+off] & 8'h3F);
                    end
                    if (!ok || cp < minv || cp > MAX_SCALAR ||
                        (cp >= SURR_FIRST && cp <= SURR_LAST)) begin
                        res[k] = make_result(repl_code, 1'b1);
                        k++;
                        pos++;
                    end else begin
                        res[k] = make_result(cp[20:0], 1'b0);
                        k++;
                        pos += need;
                    end
                end
            end
        end
        if (last && pos < n) begin
            res[k] = make_result(repl_code, 1'b1);
            k++;
            pos = n;
        end
        held_n = n - pos;
        for (int i = 0; i < held_n; i++) held_buf[i] = win[pos+i];
        if (k > 0) begin
            res[k-1].run_last = 1'b1;
            res[k-1].output_end = last;
        end
        for (int i = 0; i < k; i++) code_points_due = {code_points_due, res[i]};
    endtask

    task automatic add_byte(input logic [7:0] b, input logic last);
        q_item_t it;
        it.data_byte = b;
        it.stream_end = last;
        bytes_to_send = {bytes_to_send, it};
        queued_n++;
    endtask

    task automatic encode_cp(input int unsigned cp, output logic [7:0] e[4],
                             output int len);
        if (cp < 32'h80) begin
            len = 1; e[0] = cp[7:0];
        end else if (cp < 32'h800) begin
            len = 2;
            e[0] = 8'hC0 | cp[10:6];
            e[1] = 8'h80 | cp[5:0];
        end else if (cp < 32'h10000) begin
            len = 3;
            e[0] = 8'hE0 | cp[15:12];
            e[1] = 8'h80 | cp[11:6];
            e[2] = 8'h80 | cp[5:0];
        end else begin
            len = 4;
            e[0] = 8'hF0 | cp[20:18];
            e[1] = 8'h80 | cp[17:12];
            e[2] = 8'h80 | cp[11:6];
            e[3] = 8'h80 | cp[5:0];
        end
    endtask

    function automatic int unsigned random_scalar(int len);
        int unsigned cp;
        case (len)
            1: cp = $urandom_range(0, 32'h7F);
            2: cp = $urandom_range(32'h80, 32'h7FF);
            3: begin
                cp = $urandom_range(32'h800, 32'hFFFF);
                if (cp >= SURR_FIRST && cp <= SURR_LAST) cp -= 32'h800;
            end
            default: cp = $urandom_range(32'h10000, 32'h10FFFF);
        endcase
        return cp;
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 8'h3F));
    endfunction

    // mostly well-formed characters, the rest malformed or cut short
    task automatic random_phase(input int count);
        logic [7:0] e[4];
        int         len;
        int         cut;
        int         pick;
        bit         fin;
        logic [7:0] x;
        queued_n = 0;
        while (queued_n < count) begin
            fin = ($urandom_range(0, 11) == 0);
            pick = $urandom_range(0, 99);
            len = 0;
            if (pick < 65) begin
                encode_cp(random_scalar($urandom_range(1, 4)), e, len);
            end else begin
                case ($urandom_range(0, 7))
                    0: begin len = 1; e[0] = cont_byte(); end
                    1: begin len = 1; e[0] = 8'($urandom_range(8'hF8, 8'hFF)); end
                    2: begin
                        encode_cp(random_scalar($urandom_range(2, 4)), e, len);
                        cut = $urandom_range(1, len - 1);
                        x = 8'($urandom_range(0, 255));
                        if ((x & 8'hC0) == 8'h80) x = x ^ 8'h40;
                        e[cut] = x;
                    end
                    3: begin
                        case ($urandom_range(0, 2))
                            0: begin
                                len = 2;
                                e[0] = 8'($urandom_range(8'hC0, 8'hC1));
                            end
                            1: begin
                                len = 3; e[0] = 8'hE0;
                                e[1] = 8'($urandom_range(8'h80, 8'h9F));
                            end
                            default: begin
                                len = 4; e[0] = 8'hF0;
                                e[1] = 8'($urandom_range(8'h80, 8'h8F));
                            end
                        endcase
                        for (int i = (len > 2 ? 2 : 1); i < len; i++) e[i] = cont_byte();
                    end
                    4: begin
                        len = 3; e[0] = 8'hED;
                        e[1] = 8'($urandom_range(8'hA0, 8'hBF));
                        e[2] = cont_byte();
                    end
                    5: begin
                        len = 4;
                        if ($urandom_range(0, 1)) begin
                            e[0] = 8'hF4;
                            e[1] = 8'($urandom_range(8'h90, 8'hBF));
                        end else begin
                            e[0] = 8'($urandom_range(8'hF5, 8'hF7));
                            e[1] = cont_byte();
                        end
                        e[2] = cont_byte();
                        e[3] = cont_byte();
                    end
                    6: begin
                        encode_cp(random_scalar($urandom_range(2, 4)), e, len);
                        len = $urandom_range(1, len - 1);
                        fin = 1'b1;
                    end
                    default: begin len = 1; e[0] = 8'($urandom_range(0, 255)); end
                endcase
            end
            for (int i = 0; i < len; i++) add_byte(e[i], fin && (i == len - 1));
        end
        bytes_to_send[$].stream_end = 1'b1;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (bytes_to_send.size() != 0 || s_axis_tvalid || code_points_due.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic write_replacement(input logic [20:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        repl_code = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        q_item_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            accepted_n <= 0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                accepted_n <= accepted_n + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (bytes_to_send.size() != 0) begin
                    nxt = bytes_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nxt.data_byte;
                    s_axis_tlast <= nxt.stream_end;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long output hold, armed once in each phase that sets hold_at
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_fired <= -1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_at >= 0 && accepted_n == hold_at && hold_fired != hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_fired <= hold_at;
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_cycle = 0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
            if (hold_left != 0) m_axis_tready <= 1'b0;
            else case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= rx_cycle[2];
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        out_item_t want;
        out_item_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.code_point = m_axis_tdata[20:0];
            got.was_error  = m_axis_tuser[0];
            got.run_last   = m_axis_tuser[1];
            got.output_end = m_axis_tlast;
            if (code_points_due.size() == 0) begin
                errors++;
                $display("%0t unexpected transaction: cp %h err %b run_last %b end %b",
                         $time, got.code_point, got.was_error, got.run_last, got.output_end);
            end else begin
                want = code_points_due.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t mismatch: expected cp %h err %b run_last %b end %b",
                             $time, want.code_point, want.was_error, want.run_last,
                             want.output_end);
                    $display("%0t            actual cp %h err %b run_last %b end %b",
                             $time, got.code_point, got.was_error, got.run_last,
                             got.output_end);
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // boundaries of each length, overlong, surrogate, above max, bad leads
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b1);
        add_byte(8'hC2, 1'b0); add_byte(8'h80, 1'b0);
        add_byte(8'hEF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'hF4, 1'b0); add_byte(8'h8F, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hC1, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);
        add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hE2, 1'b0); add_byte(8'h41, 1'b0);
        add_byte(8'hF0, 1'b0); add_byte(8'h92, 1'b1);
        wait_drained();

        write_replacement(21'h000000);
        random_phase(100);
        wait_drained();

        write_replacement(21'h10FFFF);
        hold_at = accepted_n + 40;
        random_phase(100);
        wait_drained();

        write_replacement(21'h1FFFFF);
        random_phase(100);
        wait_drained();

        write_replacement(21'($urandom_range(0, 32'h10FFFF)));
        hold_at = accepted_n + 25;
        random_phase(100);
        wait_drained();

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
